// ===== src/huf_pkg.sv =====
// Package for the Huffman code builder: sizes, field widths and shared types.
// Used by huffman_code_builder_top; depends on nothing else.
package huf_pkg;

  // Build capacity and weight width.
  localparam int MAX_SYMBOLS = 16;
  localparam int WEIGHT_BITS = 16;

  // Fixed widths of the word fields.
  localparam int WEIGHT_PORT_BITS = 16;
  localparam int SYMBOL_BITS      = 4;
  localparam int CODE_BITS        = 15;
  localparam int CODE_LEN_BITS    = 4;

  // Weight bits that survive both the port width and the weight width.
  localparam int W_EFF = (WEIGHT_BITS < WEIGHT_PORT_BITS) ? WEIGHT_BITS : WEIGHT_PORT_BITS;

  // Tree storage: leaves plus internal nodes.
  localparam int NODE_COUNT = 2 * MAX_SYMBOLS - 1;
  localparam int IDX_W      = $clog2(NODE_COUNT);
  localparam int CNT_W      = $clog2(MAX_SYMBOLS + 1);
  localparam int LEN_W      = $clog2(MAX_SYMBOLS);
  localparam int NODE_W     = W_EFF + $clog2(MAX_SYMBOLS);

  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [LEN_W-1:0]      len_t;
  typedef logic [NODE_W-1:0]     wgt_t;
  typedef logic [CODE_BITS-1:0]  code_t;
  typedef logic [NODE_COUNT-1:0] node_vec_t;

endpackage

// ===== src/huffman_code_builder_top.sv =====
// Huffman code builder: stores leaf weights, builds the tree, walks out one code per symbol.
// Depends on huf_pkg for sizes and types.
// Weights without the last mark are accepted back to back.
// After the last weight, the tree is built by scanning nodes through the single weight-memory
// read port; each code is then walked out of the parent memory from leaf to root and held
// for the output handshake.
// Reset (synchronous, rst high) clears the sequencer, counters and valid flags; the node
// memories are not cleared, since every entry is written before it is read.
module huffman_code_builder_top (
  input  logic                                  clk,
  input  logic                                  rst,
  // Weight input channel.
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [huf_pkg::WEIGHT_PORT_BITS-1:0]  weight,
  input  logic                                  last_weight,
  // Code output channel.
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [huf_pkg::SYMBOL_BITS-1:0]       symbol,
  output logic [huf_pkg::CODE_BITS-1:0]         code_bits,
  output logic [huf_pkg::CODE_LEN_BITS-1:0]     code_length,
  output logic                                  last_code,
  output logic                                  dropped
);

  // The sequencer. IDLE takes weight words. SCAN streams nodes 0..k-1 through the
  // compare unit, PICK and LINK record the merge, WALK and STEP climb from a leaf
  // to the root, and EMIT holds one code word until it is taken.
  typedef enum logic [2:0] {
    IDLE,
    SCAN,
    PICK,
    LINK,
    WALK,
    STEP,
    EMIT
  } state_t;

  state_t state;

  // Set bookkeeping.
  huf_pkg::cnt_t leaf_count;
  logic          overflow_seen;
  huf_pkg::idx_t root_idx;

  // Merge bookkeeping: k is the node being created, j the scan read pointer.
  huf_pkg::idx_t k;
  huf_pkg::idx_t j;

  // Compare stage: the candidate whose weight comes out of the memory this cycle.
  logic          cand_v;
  huf_pkg::idx_t cand_idx;

  // The two lightest parentless nodes found so far in the current scan.
  logic          found1;
  logic          found2;
  huf_pkg::idx_t first_idx;
  huf_pkg::idx_t second_idx;
  huf_pkg::wgt_t first_w;
  huf_pkg::wgt_t second_w;

  // Per-node flags, kept in flip-flops so a whole build can clear has_parent at once.
  huf_pkg::node_vec_t has_parent;
  huf_pkg::node_vec_t is_right;

  // Code walk.
  huf_pkg::cnt_t sym;
  huf_pkg::idx_t pos;
  huf_pkg::code_t bits;
  huf_pkg::len_t  len;

  // Node memories: one write and one registered read each.
  huf_pkg::wgt_t weight_mem [huf_pkg::NODE_COUNT];
  huf_pkg::idx_t parent_mem [huf_pkg::NODE_COUNT];
  huf_pkg::wgt_t weight_q;
  huf_pkg::idx_t parent_q;

  logic          weight_we;
  huf_pkg::idx_t weight_waddr;
  huf_pkg::wgt_t weight_wdata;
  logic          parent_we;
  huf_pkg::idx_t parent_waddr;

  logic          in_accept;
  logic          store_leaf;
  huf_pkg::cnt_t n_next;
  huf_pkg::idx_t root_next;

  assign in_ready   = (state == IDLE);
  assign in_accept  = in_valid && in_ready;
  assign store_leaf = (leaf_count < huf_pkg::cnt_t'(huf_pkg::MAX_SYMBOLS));
  assign n_next     = store_leaf ? huf_pkg::cnt_t'(leaf_count + 1'b1) : leaf_count;
  // Root index 2n-2, worked in two extra bits and then cut to the index width.
  assign root_next  = huf_pkg::idx_t'({(huf_pkg::IDX_W + 1)'(n_next), 1'b0}
                                      - (huf_pkg::IDX_W + 2)'(2));

  // Memory write ports. Leaves are written on load, merged weights in PICK, and
  // the two parent links in PICK and LINK.
  always_comb begin
    weight_we    = 1'b0;
    weight_waddr = huf_pkg::idx_t'(leaf_count);
    weight_wdata = huf_pkg::wgt_t'(weight[huf_pkg::W_EFF-1:0]);
    parent_we    = 1'b0;
    parent_waddr = first_idx;
    case (state)
      IDLE: begin
        weight_we = in_accept && store_leaf;
      end
      PICK: begin
        weight_we    = 1'b1;
        weight_waddr = k;
        weight_wdata = first_w + second_w;
        parent_we    = 1'b1;
        parent_waddr = first_idx;
      end
      LINK: begin
        parent_we    = 1'b1;
        parent_waddr = second_idx;
      end
      default: begin
        weight_we = 1'b0;
        parent_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (weight_we) begin
      weight_mem[weight_waddr] <= weight_wdata;
    end
    weight_q <= weight_mem[j];
  end

  always_ff @(posedge clk) begin
    if (parent_we) begin
      parent_mem[parent_waddr] <= k;
    end
    parent_q <= parent_mem[pos];
  end

  // Sequencer with the compare unit and the registered outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      leaf_count    <= '0;
      overflow_seen <= 1'b0;
      cand_v        <= 1'b0;
      found1        <= 1'b0;
      found2        <= 1'b0;
      has_parent    <= '0;
      out_valid     <= 1'b0;
    end else begin
      // Compare unit: keeps the lightest and second lightest parentless nodes.
      // Candidates arrive in index order, so strict compares keep the lowest
      // index on ties.
      if (cand_v && !has_parent[cand_idx]) begin
        if (!found1 || (weight_q < first_w)) begin
          second_idx <= first_idx;
          second_w   <= first_w;
          found2     <= found1;
          first_idx  <= cand_idx;
          first_w    <= weight_q;
          found1     <= 1'b1;
        end else if (!found2 || (weight_q < second_w)) begin
          second_idx <= cand_idx;
          second_w   <= weight_q;
          found2     <= 1'b1;
        end
      end
      cand_v <= 1'b0;

      case (state)
        IDLE: begin
          if (in_accept) begin
            if (store_leaf) begin
              leaf_count <= n_next;
            end else begin
              overflow_seen <= 1'b1;
            end
            if (last_weight) begin
              has_parent <= '0;
              root_idx   <= root_next;
              k          <= huf_pkg::idx_t'(n_next);
              j          <= '0;
              found1     <= 1'b0;
              found2     <= 1'b0;
              sym        <= '0;
              pos        <= '0;
              bits       <= '0;
              len        <= '0;
              // A lone symbol needs no merge and gets the empty code.
              if (n_next > huf_pkg::cnt_t'(1)) begin
                state <= SCAN;
              end else begin
                state <= WALK;
              end
            end
          end
        end

        SCAN: begin
          if (j < k) begin
            cand_v   <= 1'b1;
            cand_idx <= j;
            j        <= j + 1'b1;
          end else begin
            state <= PICK;
          end
        end

        PICK: begin
          // The first pick is the left child.
          has_parent[first_idx] <= 1'b1;
          is_right[first_idx]   <= 1'b0;
          state                 <= LINK;
        end

        LINK: begin
          has_parent[second_idx] <= 1'b1;
          is_right[second_idx]   <= 1'b1;
          j                      <= '0;
          found1                 <= 1'b0;
          found2                 <= 1'b0;
          k                      <= k + 1'b1;
          if (k == root_idx) begin
            state <= WALK;
          end else begin
            state <= SCAN;
          end
        end

        WALK: begin
          if (has_parent[pos]) begin
            // Each level up adds the next more significant bit.
            bits  <= bits | (huf_pkg::code_t'(is_right[pos]) << len);
            len   <= len + 1'b1;
            state <= STEP;
          end else begin
            symbol      <= huf_pkg::SYMBOL_BITS'(sym);
            code_bits   <= bits;
            code_length <= huf_pkg::CODE_LEN_BITS'(len);
            last_code   <= (huf_pkg::cnt_t'(sym + 1'b1) == leaf_count);
            dropped     <= overflow_seen;
            out_valid   <= 1'b1;
            state       <= EMIT;
          end
        end

        STEP: begin
          pos   <= parent_q;
          state <= WALK;
        end

        EMIT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (huf_pkg::cnt_t'(sym + 1'b1) == leaf_count) begin
              leaf_count    <= '0;
              overflow_seen <= 1'b0;
              state         <= IDLE;
            end else begin
              sym   <= sym + 1'b1;
              pos   <= huf_pkg::idx_t'(sym + 1'b1);
              bits  <= '0;
              len   <= '0;
              state <= WALK;
            end
          end
        end

        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule
